>>> hdl/pbes_pkg.sv
// shared types, constants and the class decode for the pci enumeration sequencer
// no dependencies
package pbes_pkg;

  localparam int unsigned BusCountDef     = 256;
  localparam int unsigned DevicesDef      = 32;
  localparam int unsigned BarCountDef     = 6;

  localparam logic [15:0] AbsentId        = 16'hFFFF;
  localparam logic [7:0]  RegId           = 8'h00;
  localparam logic [7:0]  RegClass        = 8'h08;
  localparam logic [7:0]  RegHeader       = 8'h0C;
  localparam logic [7:0]  RegBar0         = 8'h10;
  localparam logic [7:0]  RegBusNum       = 8'h18;
  localparam logic [7:0]  RegIrq          = 8'h3C;

  localparam logic [1:0]  MarkNone        = 2'd0;
  localparam logic [1:0]  MarkScan        = 2'd1;
  localparam logic [1:0]  MarkDone        = 2'd2;

  localparam logic [3:0]  TypeUnknown     = 4'd0;
  localparam logic [3:0]  TypeAta         = 4'd1;
  localparam logic [3:0]  TypeAhci        = 4'd2;
  localparam logic [3:0]  TypeFloppy      = 4'd3;
  localparam logic [3:0]  TypeEthernet    = 4'd4;
  localparam logic [3:0]  TypeVga         = 4'd5;
  localparam logic [3:0]  TypeUsb         = 4'd6;
  localparam logic [3:0]  TypeAudio       = 4'd7;
  localparam logic [3:0]  TypeBridge      = 4'd8;

  typedef enum logic [2:0] {
    KIND_REQ   = 3'd0,
    KIND_BAR   = 3'd1,
    KIND_REC   = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_NOBUS = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  reg_off;
    logic        fn_zero;
    logic        bar_req;
  } desc_t;

  typedef struct packed {
    logic        load_d;
    logic        clear;
    logic        set_limit;
    logic        fn_clear;
    logic        fn_inc;
    logic        dev_inc;
    logic        load_class;
    logic        load_irq;
    logic        bar_clear;
    logic        bar_inc;
    logic        mark_sel;
    logic        mark_sec;
    logic        mem_rd;
    logic        mark_set;
    logic        srch_init;
    logic        srch_from_cursor;
    logic        srch_step;
    logic        srch_take;
    logic        srch_none;
    logic        emit;
    desc_t       desc;
  } cmd_t;

  typedef struct packed {
    logic        absent;
    logic        fn_more;
    logic        dev_more;
    logic        bar_more;
    logic        pend_zero;
    logic        bridge;
    logic [1:0]  mark_val;
    logic        in_range;
    logic        srch_end;
    logic        out_free;
  } status_t;

  function automatic logic [3:0] type_of(input logic [23:0] cls);
    logic [7:0] c;
    logic [7:0] s;
    logic [7:0] p;
    logic [3:0] t;
    c = cls[23:16];
    s = cls[15:8];
    p = cls[7:0];
    t = TypeUnknown;
    case (c)
      8'h01: begin
        if (s == 8'h01) t = TypeAta;
        else if (s == 8'h02) t = TypeFloppy;
        else if (s == 8'h06 && p == 8'h01) t = TypeAhci;
      end
      8'h02: if (s == 8'h00) t = TypeEthernet;
      8'h03: if (s == 8'h00) t = TypeVga;
      8'h04: if (s == 8'h01) t = TypeAudio;
      8'h06: if (s == 8'h04) t = TypeBridge;
      8'h0C: if (s == 8'h03) t = TypeUsb;
      default: t = TypeUnknown;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/pbes_if.sv
// valid/ready channel interfaces for the input items and the result items
// uses pbes_pkg for nothing but keeps the field widths of the block
interface pbes_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] read_data;
  modport source (output valid, output mode, output read_data, input ready);
  modport sink   (input valid, input mode, input read_data, output ready);
endinterface

interface pbes_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        last;
  logic [7:0]  bus_number;
  logic [4:0]  device_number;
  logic [2:0]  function_number;
  logic [7:0]  register_offset;
  logic [23:0] class_word;
  logic [7:0]  interrupt_pin;
  logic [7:0]  interrupt_line;
  logic [3:0]  device_type;
  logic [31:0] data_value;
  modport source (output valid, output kind, output last, output bus_number,
                  output device_number, output function_number, output register_offset,
                  output class_word, output interrupt_pin, output interrupt_line,
                  output device_type, output data_value, input ready);
  modport sink   (input valid, input kind, input last, input bus_number,
                  input device_number, input function_number, input register_offset,
                  input class_word, input interrupt_pin, input interrupt_line,
                  input device_type, input data_value, output ready);
endinterface

>>> hdl/pbes_datapath.sv
// cursors, held fields, scan-mark memory with valid bits, bus search and result register
// depends on pbes_pkg and pbes_out_if
module pbes_datapath import pbes_pkg::*; #(
  parameter int unsigned BUS_COUNT       = BusCountDef,
  parameter int unsigned DEVICES_PER_BUS = DevicesDef,
  parameter int unsigned BAR_COUNT       = BarCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [31:0] read_data_i,
  output status_t     status_o,
  pbes_out_if.source  out_o
);

  localparam int unsigned IdxW = $clog2(BUS_COUNT);

  logic [31:0]     d_q;
  logic [7:0]      bus_q;
  logic [4:0]      dev_q;
  logic [2:0]      fn_q;
  logic            multi_q;
  logic [2:0]      bar_q;
  logic [23:0]     class_q;
  logic [15:0]     irq_q;
  logic [8:0]      pend_q;
  logic [IdxW-1:0] ptr_q;
  logic [8:0]      cnt_q;

  logic [1:0]      mem [BUS_COUNT];
  logic [BUS_COUNT-1:0] vld_q;
  logic [1:0]      rd_raw_q;
  logic            rd_vld_q;

  logic [7:0]      mark_bus;
  logic [IdxW-1:0] addr;
  logic            mem_we;
  logic [1:0]      mem_wdata;
  logic [IdxW-1:0] ptr_start;
  logic [IdxW-1:0] ptr_next;

  logic            out_valid_q;

  assign mark_bus  = cmd_i.mark_sec ? d_q[15:8] : {5'b0, fn_q};
  assign addr      = cmd_i.mark_sel ? mark_bus[IdxW-1:0] : ptr_q;
  assign mem_we    = cmd_i.mark_set | cmd_i.srch_take;
  assign mem_wdata = cmd_i.srch_take ? MarkDone : MarkScan;
  assign ptr_next  = (ptr_q == IdxW'(BUS_COUNT - 1)) ? '0 : ptr_q + 1'b1;
  assign ptr_start = !cmd_i.srch_from_cursor ? '0 :
                     (bus_q[IdxW-1:0] == IdxW'(BUS_COUNT - 1)) ? '0 :
                     bus_q[IdxW-1:0] + 1'b1;

  assign status_o.absent    = (d_q[15:0] == AbsentId);
  assign status_o.fn_more   = multi_q && (fn_q != 3'd7);
  assign status_o.dev_more  = ({1'b0, dev_q} + 6'd1) < 6'(DEVICES_PER_BUS);
  assign status_o.bar_more  = ({1'b0, bar_q} + 4'd1) < 4'(BAR_COUNT);
  assign status_o.pend_zero = (pend_q == '0);
  assign status_o.bridge    = (type_of(class_q) == TypeBridge);
  assign status_o.mark_val  = rd_vld_q ? rd_raw_q : MarkNone;
  assign status_o.in_range  = {1'b0, mark_bus} < 9'(BUS_COUNT);
  assign status_o.srch_end  = (cnt_q == 9'(BUS_COUNT - 1));
  assign status_o.out_free  = !out_valid_q || out_o.ready;

  // mark memory, entries without a valid bit read as not marked
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr] <= mem_wdata;
    if (cmd_i.mem_rd) rd_raw_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clear) vld_q <= '0;
      else if (mem_we) vld_q[addr] <= 1'b1;
      if (cmd_i.mem_rd) rd_vld_q <= vld_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_d) d_q <= read_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_q   <= '0;
      dev_q   <= '0;
      fn_q    <= '0;
      multi_q <= 1'b0;
      bar_q   <= '0;
      class_q <= '0;
      irq_q   <= '0;
      pend_q  <= '0;
      ptr_q   <= '0;
      cnt_q   <= '0;
    end else if (cmd_i.clear) begin
      bus_q   <= '0;
      dev_q   <= '0;
      fn_q    <= '0;
      multi_q <= 1'b0;
      bar_q   <= '0;
      class_q <= '0;
      irq_q   <= '0;
      pend_q  <= '0;
    end else begin
      if (cmd_i.set_limit) multi_q <= d_q[23];
      if (cmd_i.fn_clear) fn_q <= '0;
      else if (cmd_i.fn_inc) fn_q <= fn_q + 1'b1;
      if (cmd_i.dev_inc) dev_q <= dev_q + 1'b1;
      if (cmd_i.load_class) class_q <= d_q[31:8];
      if (cmd_i.load_irq) irq_q <= d_q[15:0];
      if (cmd_i.bar_clear) bar_q <= '0;
      else if (cmd_i.bar_inc) bar_q <= bar_q + 1'b1;
      if (cmd_i.mark_set) pend_q <= pend_q + 1'b1;
      if (cmd_i.srch_none) pend_q <= '0;
      if (cmd_i.srch_init) begin
        ptr_q <= ptr_start;
        cnt_q <= '0;
      end else if (cmd_i.srch_step) begin
        ptr_q <= ptr_next;
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.srch_take) begin
        if (pend_q != '0) pend_q <= pend_q - 1'b1;
        bus_q <= 8'(ptr_q);
        dev_q <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.desc.kind)
        KIND_REQ: begin
          out_o.kind            <= cmd_i.desc.kind;
          out_o.last            <= 1'b1;
          out_o.bus_number      <= bus_q;
          out_o.device_number   <= dev_q;
          out_o.function_number <= cmd_i.desc.fn_zero ? 3'd0 : fn_q;
          out_o.register_offset <= cmd_i.desc.bar_req ? RegBar0 + {3'b0, bar_q, 2'b00}
                                                      : cmd_i.desc.reg_off;
          out_o.class_word      <= '0;
          out_o.interrupt_pin   <= '0;
          out_o.interrupt_line  <= '0;
          out_o.device_type     <= '0;
          out_o.data_value      <= '0;
        end
        KIND_BAR: begin
          out_o.kind            <= cmd_i.desc.kind;
          out_o.last            <= 1'b0;
          out_o.bus_number      <= bus_q;
          out_o.device_number   <= dev_q;
          out_o.function_number <= fn_q;
          out_o.register_offset <= {5'b0, bar_q};
          out_o.class_word      <= '0;
          out_o.interrupt_pin   <= '0;
          out_o.interrupt_line  <= '0;
          out_o.device_type     <= '0;
          out_o.data_value      <= d_q;
        end
        KIND_REC: begin
          out_o.kind            <= cmd_i.desc.kind;
          out_o.last            <= 1'b0;
          out_o.bus_number      <= bus_q;
          out_o.device_number   <= dev_q;
          out_o.function_number <= fn_q;
          out_o.register_offset <= '0;
          out_o.class_word      <= class_q;
          out_o.interrupt_pin   <= irq_q[15:8];
          out_o.interrupt_line  <= irq_q[7:0];
          out_o.device_type     <= type_of(class_q);
          out_o.data_value      <= '0;
        end
        default: begin
          out_o.kind            <= cmd_i.desc.kind;
          out_o.last            <= 1'b1;
          out_o.bus_number      <= '0;
          out_o.device_number   <= '0;
          out_o.function_number <= '0;
          out_o.register_offset <= '0;
          out_o.class_word      <= '0;
          out_o.interrupt_pin   <= '0;
          out_o.interrupt_line  <= '0;
          out_o.device_type     <= '0;
          out_o.data_value      <= '0;
        end
      endcase
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

>>> hdl/pbes_ctrl.sv
// controller: walk phase and sequencer state, issues datapath commands
// depends on pbes_pkg
module pbes_ctrl import pbes_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_mode_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [11:0] {
    ST_WAIT      = 12'b000000000001,
    ST_PROC      = 12'b000000000010,
    ST_EMIT      = 12'b000000000100,
    ST_ROOT_NEXT = 12'b000000001000,
    ST_ADV_DEV   = 12'b000000010000,
    ST_ADV_FN    = 12'b000000100000,
    ST_MARK_RD   = 12'b000001000000,
    ST_MARK_CHK  = 12'b000010000000,
    ST_SRCH_RD   = 12'b000100000000,
    ST_SRCH_CHK  = 12'b001000000000,
    ST_BAR_NEXT  = 12'b010000000000,
    ST_REC_NEXT  = 12'b100000000000
  } state_e;

  typedef enum logic [9:0] {
    PH_IDLE     = 10'b0000000001,
    PH_ROOT_HDR = 10'b0000000010,
    PH_ROOT_ID  = 10'b0000000100,
    PH_DEV_ID   = 10'b0000001000,
    PH_DEV_HDR  = 10'b0000010000,
    PH_FN_ID    = 10'b0000100000,
    PH_FN_CLASS = 10'b0001000000,
    PH_FN_IRQ   = 10'b0010000000,
    PH_FN_BAR   = 10'b0100000000,
    PH_FN_SEC   = 10'b1000000000
  } phase_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  phase_e phase_q, phase_d;
  desc_t  desc_q, desc_d;
  logic   in_fire;

  assign in_ready_o = (state_q == ST_WAIT);
  assign in_fire    = in_valid_i && in_ready_o;

  function automatic desc_t req(input logic [7:0] r, input logic fz);
    desc_t x;
    x.kind    = KIND_REQ;
    x.reg_off = r;
    x.fn_zero = fz;
    x.bar_req = 1'b0;
    return x;
  endfunction

  function automatic desc_t plain(input kind_e k);
    desc_t x;
    x.kind    = k;
    x.reg_off = '0;
    x.fn_zero = 1'b0;
    x.bar_req = 1'b0;
    return x;
  endfunction

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    phase_d = phase_q;
    desc_d  = desc_q;
    cmd_o   = '0;
    cmd_o.desc     = desc_q;
    cmd_o.mark_sec = (phase_q == PH_FN_SEC);
    unique case (state_q)
      ST_WAIT: begin
        cmd_o.load_d = in_fire;
        if (in_fire) begin
          if (!in_mode_i) begin
            cmd_o.clear = 1'b1;
            phase_d = PH_ROOT_HDR;
            desc_d  = req(RegHeader, 1'b1);
            ret_d   = ST_WAIT;
            state_d = ST_EMIT;
          end else if (phase_q != PH_IDLE) begin
            state_d = ST_PROC;
          end
        end
      end
      ST_PROC: begin
        ret_d   = ST_WAIT;
        state_d = ST_EMIT;
        unique case (phase_q)
          PH_ROOT_HDR, PH_DEV_HDR: begin
            cmd_o.set_limit = 1'b1;
            cmd_o.fn_clear  = 1'b1;
            phase_d = (phase_q == PH_ROOT_HDR) ? PH_ROOT_ID : PH_FN_ID;
            desc_d  = req(RegId, 1'b1);
          end
          PH_ROOT_ID: begin
            ret_d   = ST_ROOT_NEXT;
            state_d = status_i.absent ? ST_ROOT_NEXT : ST_MARK_RD;
          end
          PH_DEV_ID: begin
            if (status_i.absent) state_d = ST_ADV_DEV;
            else begin
              phase_d = PH_DEV_HDR;
              desc_d  = req(RegHeader, 1'b1);
            end
          end
          PH_FN_ID: begin
            if (status_i.absent) state_d = ST_ADV_FN;
            else begin
              phase_d = PH_FN_CLASS;
              desc_d  = req(RegClass, 1'b0);
            end
          end
          PH_FN_CLASS: begin
            cmd_o.load_class = 1'b1;
            phase_d = PH_FN_IRQ;
            desc_d  = req(RegIrq, 1'b0);
          end
          PH_FN_IRQ: begin
            cmd_o.load_irq  = 1'b1;
            cmd_o.bar_clear = 1'b1;
            phase_d = PH_FN_BAR;
            desc_d  = req(RegBar0, 1'b0);
            desc_d.bar_req = 1'b1;
          end
          PH_FN_BAR: begin
            desc_d = plain(KIND_BAR);
            ret_d  = ST_BAR_NEXT;
          end
          PH_FN_SEC: begin
            ret_d   = ST_ADV_FN;
            state_d = ST_MARK_RD;
          end
          default: state_d = ST_WAIT;
        endcase
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ret_q;
        end
      end
      ST_ROOT_NEXT: begin
        ret_d   = ST_WAIT;
        state_d = ST_EMIT;
        if (status_i.fn_more) begin
          cmd_o.fn_inc = 1'b1;
          desc_d = req(RegId, 1'b0);
        end else if (status_i.pend_zero) begin
          phase_d = PH_IDLE;
          desc_d  = plain(KIND_NOBUS);
        end else begin
          cmd_o.srch_init = 1'b1;
          state_d = ST_SRCH_RD;
        end
      end
      ST_ADV_DEV: begin
        if (status_i.dev_more) begin
          cmd_o.dev_inc = 1'b1;
          phase_d = PH_DEV_ID;
          desc_d  = req(RegId, 1'b1);
          ret_d   = ST_WAIT;
          state_d = ST_EMIT;
        end else begin
          cmd_o.srch_init        = 1'b1;
          cmd_o.srch_from_cursor = 1'b1;
          state_d = ST_SRCH_RD;
        end
      end
      ST_ADV_FN: begin
        if (status_i.fn_more) begin
          cmd_o.fn_inc = 1'b1;
          phase_d = PH_FN_ID;
          desc_d  = req(RegId, 1'b0);
          ret_d   = ST_WAIT;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_ADV_DEV;
        end
      end
      ST_MARK_RD: begin
        cmd_o.mark_sel = 1'b1;
        cmd_o.mem_rd   = 1'b1;
        state_d = ST_MARK_CHK;
      end
      ST_MARK_CHK: begin
        cmd_o.mark_sel = 1'b1;
        cmd_o.mark_set = status_i.in_range && (status_i.mark_val == MarkNone);
        state_d = ret_q;
      end
      ST_SRCH_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: begin
        if (status_i.mark_val == MarkScan) begin
          cmd_o.srch_take = 1'b1;
          phase_d = PH_DEV_ID;
          desc_d  = req(RegId, 1'b1);
          ret_d   = ST_WAIT;
          state_d = ST_EMIT;
        end else if (status_i.srch_end) begin
          cmd_o.srch_none = 1'b1;
          phase_d = PH_IDLE;
          desc_d  = plain(KIND_DONE);
          ret_d   = ST_WAIT;
          state_d = ST_EMIT;
        end else begin
          cmd_o.srch_step = 1'b1;
          state_d = ST_SRCH_RD;
        end
      end
      ST_BAR_NEXT: begin
        state_d = ST_EMIT;
        if (status_i.bar_more) begin
          cmd_o.bar_inc = 1'b1;
          desc_d = req(RegBar0, 1'b0);
          desc_d.bar_req = 1'b1;
          ret_d  = ST_WAIT;
        end else begin
          desc_d = plain(KIND_REC);
          ret_d  = ST_REC_NEXT;
        end
      end
      ST_REC_NEXT: begin
        if (status_i.bridge) begin
          phase_d = PH_FN_SEC;
          desc_d  = req(RegBusNum, 1'b0);
          ret_d   = ST_WAIT;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_ADV_FN;
        end
      end
      default: state_d = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
      ret_q   <= ST_WAIT;
      phase_q <= PH_IDLE;
      desc_q  <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      phase_q <= phase_d;
      desc_q  <= desc_d;
    end
  end

endmodule

>>> hdl/pci_bus_enumeration_sequencer_core.sv
// top level of the pci enumeration sequencer: controller plus datapath
// depends on pbes_pkg, pbes_if, pbes_ctrl and pbes_datapath
//
// A start item (mode 0) clears the scan marks and asks for the host-bridge
// header; each response item (mode 1) then yields one to three result items
// (read requests, BAR values, device records, done or no-bus error), and the
// next item is taken once the last of them has been handed to the result
// register, which can stall on the output. Advancing to a new bus searches up to
// BUS_COUNT entries of the scan-mark memory one at a time, each with a read
// state and a check state. Marks sit in a memory with one valid bit per bus,
// cleared at once by a start item.
module pci_bus_enumeration_sequencer_core import pbes_pkg::*; #(
  parameter int unsigned BUS_COUNT       = BusCountDef,
  parameter int unsigned DEVICES_PER_BUS = DevicesDef,
  parameter int unsigned BAR_COUNT       = BarCountDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pbes_in_if.sink   in_i,
  pbes_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;

  pbes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pbes_datapath #(
    .BUS_COUNT       (BUS_COUNT),
    .DEVICES_PER_BUS (DEVICES_PER_BUS),
    .BAR_COUNT       (BAR_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .read_data_i (in_i.read_data),
    .status_o    (status),
    .out_o       (out_o)
  );

endmodule
